[hw/rtl/dktpm_pkg.sv]
// ----------------------------------------------------------------------------
// dktpm_pkg: shared definitions for the digit key table prefix match unit
// Sizes, field widths, operation and result codes, the controller and
// datapath interface structs, and the digit compare helpers.
// ----------------------------------------------------------------------------
package dktpm_pkg;

    // Table and result sizing.
    localparam int TABLE_DEPTH    = 512;
    localparam int KEY_DIGITS_MAX = 6;
    localparam int MAX_MATCHES    = 16;

    // Fixed field widths of the ports.
    localparam int DIGIT_W  = 4;
    localparam int DIGITS_W = 24;
    localparam int LEN_W    = 3;
    localparam int IDX_W    = 9;
    localparam int CFG_W    = 10;
    localparam int KIND_W   = 2;

    // Derived widths.
    localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int HIT_AW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
    localparam int HIT_CW = $clog2(MAX_MATCHES + 1);
    localparam int ROW_W  = DIGITS_W + LEN_W;

    // Input operation codes.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_EXACT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PARTIAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;   // store the accepted item in the table
        logic start;   // latch the accepted query and clear the scan state
        logic scan;    // walk the table one entry per cycle
        logic emit;    // load the next result into the output register
    } dk_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // every entry read and compared
        logic out_free;    // output register can take a result this cycle
        logic emit_last;   // the result about to be loaded is the final one
    } dk_status_t;

    // Lengths above the digit capacity count as the capacity.
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] cap;
        cap = LEN_W'(KEY_DIGITS_MAX);
        return (len > cap) ? cap : len;
    endfunction

    // Number of equal leading digits, counted up to the shorter length.
    function automatic logic [LEN_W-1:0] prefix_len(
        input logic [DIGITS_W-1:0] qd,
        input logic [LEN_W-1:0]    ql,
        input logic [DIGITS_W-1:0] ed,
        input logic [LEN_W-1:0]    el
    );
        logic [LEN_W-1:0] n;
        logic [LEN_W-1:0] p;
        logic             run;
        n   = (ql < el) ? ql : el;
        p   = '0;
        run = 1'b1;
        for (int i = 0; i < KEY_DIGITS_MAX; i++) begin
            if (run && (LEN_W'(i) < n)
                && (qd[i*DIGIT_W +: DIGIT_W] == ed[i*DIGIT_W +: DIGIT_W])) begin
                p = p + LEN_W'(1);
            end else begin
                run = 1'b0;
            end
        end
        return p;
    endfunction

endpackage

[hw/rtl/digit_key_table_prefix_match_unit.sv]
// A write is stored in the table at its transfer. A query scans N entries
// through the single read port of the table memory and then loads its results
// into the output register one at a time. Throughput: writes every cycle while
// the unit is idle; after a query the next input transfer is taken only once
// its final result is loaded, which takes longer under output stall.
// Reset clears the scan count register and all control state; the table is
// undefined until written and gets no clearing pass.
// ----------------------------------------------------------------------------
// digit_key_table_prefix_match_unit: keypad digit key table lookup
// Stores digit keys in a table and answers queries with up to 16 exact
// matches, or the earliest longest-prefix match, or a single no-match result.
// ----------------------------------------------------------------------------
module digit_key_table_prefix_match_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: number of table entries that a query scans.
    input  logic                                cfg_we,
    input  logic [dktpm_pkg::CFG_W-1:0]         cfg_wdata,
    // Input channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [dktpm_pkg::IDX_W-1:0]         entry_index,
    input  logic [dktpm_pkg::DIGITS_W-1:0]      key_digits,
    input  logic [dktpm_pkg::LEN_W-1:0]         key_length,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dktpm_pkg::KIND_W-1:0]        match_kind,
    output logic [dktpm_pkg::IDX_W-1:0]         matched_entry,
    output logic [dktpm_pkg::LEN_W-1:0]         matched_digits,
    output logic                                overflowed,
    output logic                                last_result
);
    import dktpm_pkg::*;

    // The controller only ever accepts a transfer while it is idle. A write
    // transfer goes straight into the table memory; a query transfer starts
    // a scan that reads one table entry per cycle and compares it against
    // the latched query in the cycle after. Exact hits are collected in a
    // small buffer because the overflow flag on each of them is only known
    // once the scan is complete. The results then move one at a time into
    // the output register, which holds a result under stall while the
    // controller is already free to take the next input transfer.

    dk_cmd_t    cmd;
    dk_status_t status;

    dktpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dktpm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .entry_index    (entry_index),
        .key_digits     (key_digits),
        .key_length     (key_length),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_kind     (match_kind),
        .matched_entry  (matched_entry),
        .matched_digits (matched_digits),
        .overflowed     (overflowed),
        .last_result    (last_result)
    );

endmodule

[hw/rtl/dktpm_ctrl.sv]
// ----------------------------------------------------------------------------
// dktpm_ctrl: sequencing state machine
// Accepts writes and queries while idle, runs the table scan and then
// hands the results to the output register one by one.
// ----------------------------------------------------------------------------
module dktpm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  action,
    output logic                  in_stall,
    input  dktpm_pkg::dk_status_t status,
    output dktpm_pkg::dk_cmd_t    cmd
);
    import dktpm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Only one command is issued in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.write, cmd.start, cmd.scan, cmd.emit}))
        else $error("dktpm_ctrl: more than one command at once");

    // Loading the final result returns the unit to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.emit_last) |=> (state_reg == ST_IDLE))
        else $error("dktpm_ctrl: did not return to idle after the final result");

endmodule

[hw/rtl/dktpm_dp.sv]
// ----------------------------------------------------------------------------
// dktpm_dp: table memory, scan compare and result buffer
// Holds the key table and the scan count register, compares one table
// entry per cycle against the query, and keeps the exact hits and the
// best partial match until they go to the output register.
// ----------------------------------------------------------------------------
module dktpm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dktpm_pkg::dk_cmd_t                  cmd,
    output dktpm_pkg::dk_status_t               status,
    input  logic                                cfg_we,
    input  logic [dktpm_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [dktpm_pkg::IDX_W-1:0]         entry_index,
    input  logic [dktpm_pkg::DIGITS_W-1:0]      key_digits,
    input  logic [dktpm_pkg::LEN_W-1:0]         key_length,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dktpm_pkg::KIND_W-1:0]        match_kind,
    output logic [dktpm_pkg::IDX_W-1:0]         matched_entry,
    output logic [dktpm_pkg::LEN_W-1:0]         matched_digits,
    output logic                                overflowed,
    output logic                                last_result
);
    import dktpm_pkg::*;

    // Key table: digits in the low bits, clamped length on top.
    logic [ROW_W-1:0]    key_table [TABLE_DEPTH];
    logic [ROW_W-1:0]    rd_data_reg;
    logic [TBL_AW-1:0]   rd_idx_reg;
    logic                rd_valid_reg;
    logic                rd_valid_next;

    logic [CFG_W-1:0]    entries_reg;
    logic [CFG_W-1:0]    entries_next;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic [CNT_W-1:0]    scan_cnt_next;
    logic [CNT_W-1:0]    scan_lim_reg;
    logic [CNT_W-1:0]    scan_lim_next;
    logic                scan_issue;

    logic [DIGITS_W-1:0] q_digits_reg;
    logic [DIGITS_W-1:0] q_digits_next;
    logic [LEN_W-1:0]    q_len_reg;
    logic [LEN_W-1:0]    q_len_next;

    logic [TBL_AW-1:0]   hit_buf_reg [MAX_MATCHES];
    logic [HIT_CW-1:0]   nhits_reg;
    logic [HIT_CW-1:0]   nhits_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [LEN_W-1:0]    best_len_reg;
    logic [LEN_W-1:0]    best_len_next;
    logic [TBL_AW-1:0]   best_idx_reg;
    logic [TBL_AW-1:0]   best_idx_next;
    logic [HIT_AW-1:0]   emit_ptr_reg;
    logic [HIT_AW-1:0]   emit_ptr_next;

    logic [LEN_W-1:0]    cmp_prefix;
    logic                cmp_exact;
    logic                hit_push;
    logic [LEN_W-1:0]    wr_len;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [KIND_W-1:0]   kind_reg;
    logic [KIND_W-1:0]   kind_next;
    logic [IDX_W-1:0]    entry_reg;
    logic [IDX_W-1:0]    entry_next;
    logic [LEN_W-1:0]    digits_reg;
    logic [LEN_W-1:0]    digits_next;
    logic                ovf_out_reg;
    logic                ovf_out_next;
    logic                last_reg;
    logic                last_next;

    assign wr_len     = clamp_len(key_length);
    assign scan_issue = cmd.scan && (scan_cnt_reg != scan_lim_reg);

    // Compare the entry read in the previous cycle.
    assign cmp_prefix = prefix_len(q_digits_reg, q_len_reg,
                                   rd_data_reg[DIGITS_W-1:0],
                                   rd_data_reg[ROW_W-1:DIGITS_W]);
    assign cmp_exact  = (q_len_reg == rd_data_reg[ROW_W-1:DIGITS_W])
                        && (cmp_prefix == q_len_reg);
    assign hit_push   = rd_valid_reg && cmp_exact
                        && (nhits_reg != HIT_CW'(MAX_MATCHES));

    assign status.scan_done = (scan_cnt_reg == scan_lim_reg) && !rd_valid_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.emit_last = (nhits_reg == '0)
                              || (HIT_CW'(emit_ptr_reg) == nhits_reg - HIT_CW'(1));

    always_comb
    begin
        entries_next  = cfg_we ? cfg_wdata : entries_reg;
        scan_cnt_next = scan_cnt_reg;
        scan_lim_next = scan_lim_reg;
        q_digits_next = q_digits_reg;
        q_len_next    = q_len_reg;
        nhits_next    = nhits_reg;
        ovf_next      = ovf_reg;
        best_len_next = best_len_reg;
        best_idx_next = best_idx_reg;
        emit_ptr_next = emit_ptr_reg;
        rd_valid_next = scan_issue;

        if (cmd.start)
        begin
            scan_cnt_next = '0;
            scan_lim_next = (entries_reg > CFG_W'(TABLE_DEPTH))
                            ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries_reg);
            q_digits_next = key_digits;
            q_len_next    = clamp_len(key_length);
            nhits_next    = '0;
            ovf_next      = 1'b0;
            best_len_next = '0;
            best_idx_next = '0;
            emit_ptr_next = '0;
        end
        else
        begin
            if (scan_issue)
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
            end
            if (rd_valid_reg)
            begin
                priority if (cmp_exact)
                begin
                    if (hit_push)
                    begin
                        nhits_next = nhits_reg + HIT_CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (cmp_prefix > best_len_reg)
                begin
                    best_len_next = cmp_prefix;
                    best_idx_next = rd_idx_reg;
                end
            end
            if (cmd.emit)
            begin
                emit_ptr_next = emit_ptr_reg + HIT_AW'(1);
            end
        end
    end

    // Output register: exact hits first, else the best prefix, else none.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        entry_next     = entry_reg;
        digits_next    = digits_reg;
        ovf_out_next   = ovf_out_reg;
        last_next      = last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            last_next      = status.emit_last;
            priority if (nhits_reg != '0)
            begin
                kind_next    = KIND_EXACT;
                entry_next   = IDX_W'(hit_buf_reg[emit_ptr_reg]);
                digits_next  = q_len_reg;
                ovf_out_next = ovf_reg;
            end
            else if (best_len_reg != '0)
            begin
                kind_next    = KIND_PARTIAL;
                entry_next   = IDX_W'(best_idx_reg);
                digits_next  = best_len_reg;
                ovf_out_next = 1'b0;
            end
            else
            begin
                kind_next    = KIND_NONE;
                entry_next   = '0;
                digits_next  = '0;
                ovf_out_next = 1'b0;
            end
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write && (int'(entry_index) < TABLE_DEPTH))
        begin
            key_table[entry_index[TBL_AW-1:0]] <= {wr_len, key_digits};
        end
        if (scan_issue)
        begin
            rd_data_reg <= key_table[scan_cnt_reg[TBL_AW-1:0]];
            rd_idx_reg  <= scan_cnt_reg[TBL_AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_push && !cmd.start)
        begin
            hit_buf_reg[nhits_reg[HIT_AW-1:0]] <= rd_idx_reg;
        end
        q_digits_reg  <= q_digits_next;
        best_idx_reg  <= best_idx_next;
        kind_reg      <= kind_next;
        entry_reg     <= entry_next;
        digits_reg    <= digits_next;
        ovf_out_reg   <= ovf_out_next;
        last_reg      <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= '0;
            scan_cnt_reg  <= '0;
            scan_lim_reg  <= '0;
            q_len_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            nhits_reg     <= '0;
            ovf_reg       <= 1'b0;
            best_len_reg  <= '0;
            emit_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            entries_reg   <= entries_next;
            scan_cnt_reg  <= scan_cnt_next;
            scan_lim_reg  <= scan_lim_next;
            q_len_reg     <= q_len_next;
            rd_valid_reg  <= rd_valid_next;
            nhits_reg     <= nhits_next;
            ovf_reg       <= ovf_next;
            best_len_reg  <= best_len_next;
            emit_ptr_reg  <= emit_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign match_kind     = kind_reg;
    assign matched_entry  = entry_reg;
    assign matched_digits = digits_reg;
    assign overflowed     = ovf_out_reg;
    assign last_result    = last_reg;

    // Dropped exact matches are only possible once the hit buffer is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (nhits_reg == HIT_CW'(MAX_MATCHES)))
        else $error("dktpm_dp: overflow flagged with room in the hit buffer");

    // The scan address never runs past the latched scan limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (scan_cnt_reg <= scan_lim_reg))
        else $error("dktpm_dp: scan count beyond the scan limit");

    // A partial prefix can never be longer than the query itself.
    assert property (@(posedge clk) disable iff (!rst_n)
        (best_len_reg <= q_len_reg))
        else $error("dktpm_dp: best prefix longer than the query");

endmodule
